/* rtl/core/integer_literal_parser_core_assert.svh */
// Assertion macros used by the integer literal parser top level.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ILP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("integer literal parser check failed");

// Next-cycle implication, disabled while reset is held.
`define ILP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("integer literal parser check failed");

`endif

/* rtl/core/ilp_pkg.sv */
// Shared types, codes and constants of the integer literal parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ilp_pkg;

    localparam int MAX_DIGITS = 2047;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 2);

    // Token kinds.
    localparam logic [1:0] KIND_DEC = 2'd0;
    localparam logic [1:0] KIND_HEX = 2'd1;
    localparam logic [1:0] KIND_BIN = 2'd2;
    localparam logic [1:0] KIND_OCT = 2'd3;

    // Token phases.
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_DIGITS = 3'd2;
    localparam logic [2:0] PH_MARKER = 3'd3;
    localparam logic [2:0] PH_WIDTH  = 3'd4;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_SUFFIX   = 3'd4;

    // Type codes; bit 2 marks unsigned.
    localparam logic [2:0] TY_I8  = 3'd0;
    localparam logic [2:0] TY_I16 = 3'd1;
    localparam logic [2:0] TY_I32 = 3'd2;
    localparam logic [2:0] TY_I64 = 3'd3;

    // Character codes.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_LO_I  = 8'h69;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_U  = 8'h75;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_CASE  = 8'h20;

    typedef struct packed {
        logic [2:0]       phase;
        logic [63:0]      acc;
        logic             ovf;
        logic [CNT_W-1:0] cnt;
        logic             is_unsigned;
        logic [7:0]       width_num;
        logic             width_given;
        logic             suffix_err;
    } t_ilp_state;

    localparam t_ilp_state STATE_CLEAR = '{
        phase:       PH_START,
        acc:         64'd0,
        ovf:         1'b0,
        cnt:         '0,
        is_unsigned: 1'b0,
        width_num:   8'd0,
        width_given: 1'b0,
        suffix_err:  1'b0
    };

endpackage

/* rtl/core/ilp_step.sv */
// Per-character next-state logic: prefix skip, digit accumulate, suffix parse.
// Depends on ilp_pkg.
`timescale 1ns / 1ps

module ilp_step import ilp_pkg::*; (
    input  t_ilp_state i_state,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_char,
    output t_ilp_state o_state
);

    logic [7:0]  low_c;
    logic        is_dec;
    logic        is_hex;
    logic [3:0]  dval;
    logic        dig_ok;
    logic        prefix_hit;
    logic        marker_hit;
    logic        in_digits;
    logic [67:0] scaled;
    logic [67:0] summed;
    logic [11:0] wsum;

    always_comb begin
        low_c  = (i_char >= CH_UP_A && i_char <= CH_UP_Z) ? i_char + CH_CASE : i_char;
        is_dec = (i_char >= CH_0 && i_char <= CH_9);
        is_hex = (low_c >= CH_LO_A && low_c <= CH_LO_F);
        dval   = is_dec ? i_char[3:0] : low_c[3:0] + 4'd9;
        unique case (i_kind)
            KIND_DEC: dig_ok = is_dec;
            KIND_HEX: dig_ok = is_dec || is_hex;
            KIND_BIN: dig_ok = is_dec && dval <= 4'd1;
            KIND_OCT: dig_ok = is_dec && dval <= 4'd7;
            default:  dig_ok = 1'b0;
        endcase

        // Radix multiply as shifts; the top four bits catch 64-bit overflow.
        unique case (i_kind)
            KIND_DEC: scaled = {1'b0, i_state.acc, 3'b000} + {3'b000, i_state.acc, 1'b0};
            KIND_HEX: scaled = {i_state.acc, 4'b0000};
            KIND_BIN: scaled = {3'b000, i_state.acc, 1'b0};
            KIND_OCT: scaled = {1'b0, i_state.acc, 3'b000};
            default:  scaled = {4'b0000, i_state.acc};
        endcase
        summed = scaled + {64'd0, dval};

        prefix_hit = (i_kind == KIND_HEX && low_c == CH_LO_X)
                  || (i_kind == KIND_BIN && low_c == CH_LO_B)
                  || (i_kind == KIND_OCT && low_c == CH_LO_O);
        marker_hit = (i_kind == KIND_HEX && low_c == CH_LO_H)
                  || (i_kind == KIND_BIN && low_c == CH_LO_B)
                  || (i_kind == KIND_OCT && low_c == CH_LO_O);
        in_digits  = (i_state.phase == PH_START) || (i_state.phase == PH_ZERO)
                  || (i_state.phase == PH_DIGITS);

        wsum = {4'd0, i_state.width_num} * 12'd10 + {8'd0, i_char[3:0]};

        o_state = i_state;
        if (i_state.suffix_err) begin
            o_state = i_state;
        end else if (i_state.phase == PH_ZERO && prefix_hit) begin
            // A radix prefix discards the leading zero.
            o_state.acc   = 64'd0;
            o_state.cnt   = '0;
            o_state.phase = PH_DIGITS;
        end else if (in_digits) begin
            if (i_char == CH_UNDER) begin
                o_state.phase = PH_DIGITS;
            end else if (dig_ok) begin
                o_state.acc = summed[63:0];
                o_state.ovf = i_state.ovf || (summed[67:64] != 4'd0);
                if (i_state.cnt <= CNT_W'(MAX_DIGITS)) begin
                    o_state.cnt = i_state.cnt + 1'b1;
                end
                o_state.phase = (i_state.phase == PH_START && i_char == CH_0)
                              ? PH_ZERO : PH_DIGITS;
            end else if (marker_hit) begin
                o_state.phase = PH_MARKER;
            end else if (low_c == CH_LO_I || low_c == CH_LO_U) begin
                o_state.is_unsigned = (low_c == CH_LO_U);
                o_state.phase       = PH_WIDTH;
            end else begin
                o_state.suffix_err = 1'b1;
            end
        end else if (i_state.phase == PH_MARKER) begin
            if (low_c == CH_LO_I || low_c == CH_LO_U) begin
                o_state.is_unsigned = (low_c == CH_LO_U);
                o_state.phase       = PH_WIDTH;
            end else begin
                o_state.suffix_err = 1'b1;
            end
        end else if (i_state.phase == PH_WIDTH && is_dec) begin
            o_state.width_num   = (wsum > 12'd255) ? 8'd255 : wsum[7:0];
            o_state.width_given = 1'b1;
        end else begin
            o_state.suffix_err = 1'b1;
        end
    end

endmodule

/* rtl/core/ilp_finish.sv */
// End-of-token evaluation: status priority, type selection and range checks.
// Depends on ilp_pkg.
`timescale 1ns / 1ps

module ilp_finish import ilp_pkg::*; (
    input  t_ilp_state  i_state,
    output logic [63:0] o_value,
    output logic [2:0]  o_type,
    output logic [2:0]  o_status
);

    logic [7:0] w;
    logic       bad_width;
    logic       too_big;
    logic [2:0] code;
    logic [2:0] status;

    always_comb begin
        w = i_state.width_given ? i_state.width_num : 8'd32;
        bad_width = 1'b0;
        too_big   = 1'b0;
        code      = TY_I64;
        unique case (w)
            8'd8: begin
                code    = TY_I8;
                too_big = i_state.is_unsigned ? (i_state.acc[63:8] != '0)
                                              : (i_state.acc[63:7] != '0);
            end
            8'd16: begin
                code    = TY_I16;
                too_big = i_state.is_unsigned ? (i_state.acc[63:16] != '0)
                                              : (i_state.acc[63:15] != '0);
            end
            8'd32: begin
                code    = TY_I32;
                too_big = i_state.is_unsigned ? (i_state.acc[63:32] != '0)
                                              : (i_state.acc[63:31] != '0);
            end
            8'd64: begin
                code = TY_I64;
            end
            default: begin
                bad_width = 1'b1;
            end
        endcase

        status = ST_OK;
        priority if (i_state.suffix_err || (i_state.width_given && i_state.width_num == 8'd0)) begin
            status = ST_SUFFIX;
        end else if (i_state.cnt == '0 || i_state.cnt > CNT_W'(MAX_DIGITS)) begin
            status = ST_LENGTH;
        end else if (i_state.ovf || (!i_state.is_unsigned && i_state.acc[63])) begin
            status = ST_OVERFLOW;
        end else if (bad_width) begin
            status = ST_SUFFIX;
        end else if (too_big) begin
            // Without a written width the literal is promoted to 64 bits.
            if (i_state.width_given) begin
                status = ST_RANGE;
            end else begin
                code = TY_I64;
            end
        end

        if (status == ST_OK) begin
            o_value = i_state.acc;
            o_type  = {i_state.is_unsigned, code[1:0]};
        end else begin
            o_value = 64'd0;
            o_type  = TY_I8;
        end
        o_status = status;
    end

endmodule

/* rtl/core/integer_literal_parser_core.sv */
// Integer literal parser: top level with input, snapshot and result registers.
// Depends on ilp_pkg, ilp_step, ilp_finish and integer_literal_parser_core_assert.svh.
//
// Usage: each input word carries one character of a number token, the token's
// radix kind (decimal, hexadecimal, binary, octal) and a token-end mark on the
// last character. The word is accepted on a rising edge where i_valid is high
// and o_stall is low. Characters without the end mark produce no output word.
// For a word with the end mark, one output word (value, type code, status)
// appears on o_valid after passing the snapshot and result registers, and it is taken at
// the edge where o_valid is high and i_stall is low.
// Throughput is one character word per cycle while o_stall is low. The update
// per character is a radix shift-add on the 64-bit accumulator plus suffix
// decoding, done combinationally between the input register and the token state.
// When the receiver stalls, the result register holds its word; one more
// finished token can wait in the snapshot register, and only when both are
// full does o_stall rise toward the sender.
// Reset (synchronous, active low) empties all three stages and returns the
// token state to the start of a token; no clearing pass is needed.
`timescale 1ns / 1ps
`include "integer_literal_parser_core_assert.svh"

module integer_literal_parser_core import ilp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_radix_kind,
    input  logic [7:0]  i_char_code,
    input  logic        i_token_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_literal_value,
    output logic [2:0]  o_type_code,
    output logic [2:0]  o_status
);

    // Input register.
    logic       r_in_valid;
    logic [1:0] r_in_kind;
    logic [7:0] r_in_char;
    logic       r_in_end;

    // Running token state.
    t_ilp_state r_state;
    t_ilp_state n_state;

    // Snapshot of a finished token, waiting for evaluation.
    logic       r_fin_valid;
    t_ilp_state r_fin_state;

    // Result register.
    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic [2:0]  r_out_type;
    logic [2:0]  r_out_status;

    logic        out_adv;
    logic        fin_adv;
    logic        in_go;
    logic        fin_load;
    logic [63:0] fin_value;
    logic [2:0]  fin_type;
    logic [2:0]  fin_status;

    ilp_step u_step (
        .i_state (r_state),
        .i_kind  (r_in_kind),
        .i_char  (r_in_char),
        .o_state (n_state)
    );

    ilp_finish u_finish (
        .i_state  (r_fin_state),
        .o_value  (fin_value),
        .o_type   (fin_type),
        .o_status (fin_status)
    );

    // Each stage moves when the stage after it is empty or draining.
    assign out_adv  = !r_out_valid || !i_stall;
    assign fin_adv  = !r_fin_valid || out_adv;
    assign in_go    = r_in_valid && fin_adv;
    assign fin_load = in_go && r_in_end;
    assign o_stall  = r_in_valid && !fin_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_kind <= i_radix_kind;
            r_in_char <= i_char_code;
            r_in_end  <= i_token_end;
        end
    end

    // The last character of a token hands its state to the snapshot and
    // restarts the token state in the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_CLEAR;
        end else if (in_go) begin
            r_state <= r_in_end ? STATE_CLEAR : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_adv) begin
            r_fin_valid <= fin_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_fin_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_fin_valid) begin
            r_out_value  <= fin_value;
            r_out_type   <= fin_type;
            r_out_status <= fin_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_literal_value = r_out_value;
    assign o_type_code     = r_out_type;
    assign o_status        = r_out_status;

    // A failed token reports zero value and type.
    `ILP_ASSERT_SAME(a_fail_zeroed, o_valid && o_status != ST_OK, o_literal_value == 64'd0 && o_type_code == TY_I8)
    // A signed result always fits in 63 bits.
    `ILP_ASSERT_SAME(a_signed_fits, o_valid && o_status == ST_OK && !o_type_code[2], !o_literal_value[63])
    // After a token end the running state is back at the start of a token.
    `ILP_ASSERT_NEXT(a_token_restart, fin_load, r_state.phase == PH_START && r_state.cnt == '0 && !r_state.suffix_err)

endmodule
